// ===== design/dcme_pkg.sv =====
// Shared types, constants and codes for the DC motor Euler step core.
`default_nettype none

package dcme_pkg;

    // Field widths
    localparam int COEF_W    = 32;   // Q16.16 coefficients, voltage, current, speed
    localparam int ANGLE_W   = 48;   // Q32.16 wrapping angle
    localparam int PROD_W    = 48;   // floored product, 16 fraction bits dropped
    localparam int ACC_W     = 50;   // sum of state plus three floored products
    localparam int FRAC_W    = 16;
    localparam int SUBSTEP_W = 5;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_SUBSTEPS = 16;

    localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_DECAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTEPS      = 3'd6;

    // One substep is seven phases of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        PH_LOAD_I,      // mul volt_gain*voltage, acc <= current
        PH_ADD_VOLT,    // mul current_decay*current, acc += volt term
        PH_SUB_DECAY,   // mul back_emf_gain*speed, acc -= decay term
        PH_STORE_I,     // mul torque_gain*current, new current, acc <= speed
        PH_ADD_TORQUE,  // mul friction_gain*speed, acc += torque term
        PH_STORE_W,     // mul step_length*speed, new speed, acc <= angle
        PH_COMMIT       // angle += angle term, commit current and speed
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } seq_state_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic   load;    // latch a new voltage request
        logic   run;     // phase below is live this cycle
        phase_t phase;
        logic   finish;  // move state into the output register
    } ctrl_t;

endpackage : dcme_pkg

`default_nettype wire

// ===== design/dcme_seq.sv =====
// Substep and phase sequencer of the DC motor Euler step core.
`default_nettype none

module dcme_seq import dcme_pkg::*; #(
    parameter int MAX_SUBSTEPS = DEF_MAX_SUBSTEPS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_free,
    input  wire logic [SUBSTEP_W-1:0] substeps,
    output logic                      busy,
    output ctrl_t                     ctrl
);

    localparam int CNT_W = $clog2(MAX_SUBSTEPS + 1);
    localparam int CMP_W = (CNT_W > SUBSTEP_W) ? CNT_W : SUBSTEP_W;

    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  left_reg,  left_next;

    logic [CMP_W-1:0]  sub_ext;
    logic [CMP_W-1:0]  max_ext;
    logic [CNT_W-1:0]  count_eff;
    logic              accept;

    // Clamp the substep count to one .. MAX_SUBSTEPS
    always_comb
    begin
        sub_ext = CMP_W'(substeps);
        max_ext = CMP_W'(MAX_SUBSTEPS);
        if (sub_ext == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (sub_ext > max_ext)
        begin
            count_eff = CNT_W'(MAX_SUBSTEPS);
        end
        else
        begin
            count_eff = sub_ext[CNT_W-1:0];
        end
    end

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LOAD_I;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        left_next    = left_reg;
        ctrl.load    = 1'b0;
        ctrl.run     = 1'b0;
        ctrl.phase   = phase_reg;
        ctrl.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_RUN;
                    phase_next = PH_LOAD_I;
                    left_next  = count_eff;
                end
            end
            ST_RUN:
            begin
                ctrl.run = 1'b1;
                if (phase_reg == PH_COMMIT)
                begin
                    phase_next = PH_LOAD_I;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                    left_next = left_reg - CNT_W'(1);
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_last_substep_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && phase_reg == PH_COMMIT && left_reg == CNT_W'(1))
        |=> (state_reg == ST_FINISH))
        else $error("last substep did not lead to finish");

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (left_reg != '0))
        else $error("running with no substeps left");

    a_accept_starts_substep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && phase_reg == PH_LOAD_I))
        else $error("accepted request did not start at the first phase");

endmodule : dcme_seq

`default_nettype wire

// ===== design/dcme_datapath.sv =====
// Shared multiply-accumulate datapath and motor state of the Euler step core.
`default_nettype none

module dcme_datapath import dcme_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ctrl_t                     ctrl,
    input  wire logic signed [COEF_W-1:0]  voltage,
    input  wire logic signed [COEF_W-1:0]  volt_gain,
    input  wire logic signed [COEF_W-1:0]  current_decay,
    input  wire logic signed [COEF_W-1:0]  back_emf_gain,
    input  wire logic signed [COEF_W-1:0]  torque_gain,
    input  wire logic signed [COEF_W-1:0]  friction_gain,
    input  wire logic signed [COEF_W-1:0]  step_length,
    output logic signed [COEF_W-1:0]       current,
    output logic signed [COEF_W-1:0]       speed,
    output logic signed [ANGLE_W-1:0]      angle
);

    logic signed [COEF_W-1:0]   volt_reg;
    logic signed [PROD_W-1:0]   prod_reg,    prod_next;
    logic signed [ACC_W-1:0]    acc_reg,     acc_next;
    logic signed [COEF_W-1:0]   ni_reg,      ni_next;
    logic signed [COEF_W-1:0]   nw_reg,      nw_next;
    logic signed [COEF_W-1:0]   current_reg, current_next;
    logic signed [COEF_W-1:0]   speed_reg,   speed_next;
    logic signed [ANGLE_W-1:0]  angle_reg,   angle_next;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [2*COEF_W-1:0] mul_full;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W-1:0]    sum;
    logic                       subtract;
    logic [COEF_W-1:0]          sum_sat;
    logic [ACC_W-COEF_W:0]      sum_hi;

    // Operand select for the single multiplier
    always_comb
    begin
        case (ctrl.phase)
            PH_LOAD_I:
            begin
                mul_a = volt_gain;
                mul_b = volt_reg;
            end
            PH_ADD_VOLT:
            begin
                mul_a = current_decay;
                mul_b = current_reg;
            end
            PH_SUB_DECAY:
            begin
                mul_a = back_emf_gain;
                mul_b = speed_reg;
            end
            PH_STORE_I:
            begin
                mul_a = torque_gain;
                mul_b = current_reg;
            end
            PH_ADD_TORQUE:
            begin
                mul_a = friction_gain;
                mul_b = speed_reg;
            end
            default:
            begin
                mul_a = step_length;
                mul_b = speed_reg;
            end
        endcase
    end

    // Floor to 16 fraction bits by dropping them from the exact product
    assign mul_full  = mul_a * mul_b;
    assign prod_next = mul_full[2*COEF_W-1:FRAC_W];

    always_comb
    begin
        case (ctrl.phase) inside
            PH_SUB_DECAY, PH_STORE_I, PH_STORE_W: subtract = 1'b1;
            default:                              subtract = 1'b0;
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign addend   = subtract ? -prod_ext : prod_ext;
    assign sum      = acc_reg + addend;

    // Saturate the finished sum to the signed 32-bit range
    assign sum_hi = sum[ACC_W-1:COEF_W-1];
    always_comb
    begin
        if ((sum_hi == '0) || (sum_hi == '1))
        begin
            sum_sat = sum[COEF_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            sum_sat = SAT_MIN;
        end
        else
        begin
            sum_sat = SAT_MAX;
        end
    end

    always_comb
    begin
        acc_next     = acc_reg;
        ni_next      = ni_reg;
        nw_next      = nw_reg;
        current_next = current_reg;
        speed_next   = speed_reg;
        angle_next   = angle_reg;
        if (ctrl.run)
        begin
            case (ctrl.phase)
                PH_LOAD_I:
                begin
                    acc_next = ACC_W'(current_reg);
                end
                PH_STORE_I:
                begin
                    ni_next  = sum_sat;
                    acc_next = ACC_W'(speed_reg);
                end
                PH_STORE_W:
                begin
                    nw_next  = sum_sat;
                    acc_next = ACC_W'(angle_reg);
                end
                PH_COMMIT:
                begin
                    angle_next   = sum[ANGLE_W-1:0];
                    current_next = ni_reg;
                    speed_next   = nw_reg;
                end
                default:
                begin
                    acc_next = sum;
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            volt_reg <= voltage;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        ni_reg   <= ni_next;
        nw_reg   <= nw_next;
    end

    // Motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= '0;
            speed_reg   <= '0;
            angle_reg   <= '0;
        end
        else
        begin
            current_reg <= current_next;
            speed_reg   <= speed_next;
            angle_reg   <= angle_next;
        end
    end

    assign current = current_reg;
    assign speed   = speed_reg;
    assign angle   = angle_reg;

    a_state_only_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.run && ctrl.phase == PH_COMMIT) |=> $stable(angle_reg))
        else $error("angle moved outside the commit phase");

endmodule : dcme_datapath

`default_nettype wire

// ===== design/dc_motor_euler_step_core.sv =====
// Top level of the DC motor Euler step core: ports, configuration and result register.
`default_nettype none

// DC motor Euler step core. Each voltage request advances a DC motor model
// (current, shaft speed, wrapping 48-bit angle) by one step of "substeps"
// forward Euler substeps, clamped to 1..MAX_SUBSTEPS, and returns one
// result with the new current, speed and angle. All values are signed
// Q16.16 (angle Q32.16); each coefficient product is floored to 16
// fraction bits, and current and speed saturate to 32 bits per substep.
// A single 32x32 multiplier with one accumulator does all the work, one
// product per cycle. A request is accepted while the core is idle, then
// integrated over n substeps (n the clamped substep count), and its state
// is then moved into the result register. in_stall is low only while the
// core is idle and stays high until that state has been moved into the
// result register. The result register holds a finished result while the
// next request is already being worked on; only a second finish waits for
// it to drain, and in_stall stays high through that wait. Write the
// configuration only while the core is idle; cfg_ready is always high.

module dc_motor_euler_step_core import dcme_pkg::*; #(
    parameter int MAX_SUBSTEPS = DEF_MAX_SUBSTEPS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COEF_W-1:0]         cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COEF_W-1:0]  voltage,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [COEF_W-1:0]       current_out,
    output logic signed [COEF_W-1:0]       speed_out,
    output logic signed [ANGLE_W-1:0]      angle_out
);

    // Configuration registers
    logic signed [COEF_W-1:0] volt_gain_reg;
    logic signed [COEF_W-1:0] current_decay_reg;
    logic signed [COEF_W-1:0] back_emf_gain_reg;
    logic signed [COEF_W-1:0] torque_gain_reg;
    logic signed [COEF_W-1:0] friction_gain_reg;
    logic signed [COEF_W-1:0] step_length_reg;
    logic [SUBSTEP_W-1:0]     substeps_reg;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic signed [COEF_W-1:0]  current_out_reg;
    logic signed [COEF_W-1:0]  speed_out_reg;
    logic signed [ANGLE_W-1:0] angle_out_reg;

    logic                      out_free;
    logic                      busy;
    logic                      cfg_write;
    ctrl_t                     ctrl;
    logic signed [COEF_W-1:0]  current_state;
    logic signed [COEF_W-1:0]  speed_state;
    logic signed [ANGLE_W-1:0] angle_state;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_gain_reg     <= '0;
            current_decay_reg <= '0;
            back_emf_gain_reg <= '0;
            torque_gain_reg   <= '0;
            friction_gain_reg <= '0;
            step_length_reg   <= '0;
            substeps_reg      <= SUBSTEP_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VOLT_GAIN:     volt_gain_reg     <= cfg_data;
                REG_CURRENT_DECAY: current_decay_reg <= cfg_data;
                REG_BACK_EMF_GAIN: back_emf_gain_reg <= cfg_data;
                REG_TORQUE_GAIN:   torque_gain_reg   <= cfg_data;
                REG_FRICTION_GAIN: friction_gain_reg <= cfg_data;
                REG_STEP_LENGTH:   step_length_reg   <= cfg_data;
                REG_SUBSTEPS:      substeps_reg      <= cfg_data[SUBSTEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // The result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy;

    dcme_seq #(
        .MAX_SUBSTEPS (MAX_SUBSTEPS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .substeps (substeps_reg),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    dcme_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .voltage       (voltage),
        .volt_gain     (volt_gain_reg),
        .current_decay (current_decay_reg),
        .back_emf_gain (back_emf_gain_reg),
        .torque_gain   (torque_gain_reg),
        .friction_gain (friction_gain_reg),
        .step_length   (step_length_reg),
        .current       (current_state),
        .speed         (speed_state),
        .angle         (angle_state)
    );

    // Hold the result until taken; load a new one only when free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            current_out_reg <= current_state;
            speed_out_reg   <= speed_state;
            angle_out_reg   <= angle_state;
        end
    end

    assign out_valid   = out_valid_reg;
    assign current_out = current_out_reg;
    assign speed_out   = speed_out_reg;
    assign angle_out   = angle_out_reg;

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> out_free)
        else $error("result loaded over an untaken result");

    a_no_accept_while_finishing: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> !ctrl.load)
        else $error("request accepted in the finishing cycle");

    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> (out_valid_reg && current_out_reg == current_state))
        else $error("finished result not presented");

endmodule : dc_motor_euler_step_core

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the DC motor Euler step core.
`timescale 1ns / 100ps

module tb;
    import dcme_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int STEP_LIMIT    = DEF_MAX_SUBSTEPS;
    // Busy time of one request at the substep limit when its result is taken at once
    localparam int BUSY_CYCLES   = 7 * STEP_LIMIT + 2;
    localparam int SETTLE_CYCLES = 2 * BUSY_CYCLES;
    localparam int QUIET_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    // Index past the last register: the core must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [COEF_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [COEF_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_MIN = 32'h8000_0000;
    localparam longint Q_HIGH = 64'sd2147483647;
    localparam longint Q_LOW  = -64'sd2147483648;

    typedef struct {
        logic signed [COEF_W-1:0] current;
        logic signed [COEF_W-1:0] speed;
        logic [ANGLE_W-1:0]       angle;
    } motor_state_t;

    // Holds its own copy of the coefficients and the motor state, integrates
    // each accepted request and keeps the resulting states in arrival order.
    class motor_step_scoreboard;
        logic signed [COEF_W-1:0] volt_gain;
        logic signed [COEF_W-1:0] current_decay;
        logic signed [COEF_W-1:0] back_emf_gain;
        logic signed [COEF_W-1:0] torque_gain;
        logic signed [COEF_W-1:0] friction_gain;
        logic signed [COEF_W-1:0] step_length;
        logic [SUBSTEP_W-1:0]     substeps;
        logic signed [COEF_W-1:0] current;
        logic signed [COEF_W-1:0] speed;
        logic [ANGLE_W-1:0]       angle;
        motor_state_t             expected_states[$];
        int                       failures;

        function new();
            volt_gain     = '0;
            current_decay = '0;
            back_emf_gain = '0;
            torque_gain   = '0;
            friction_gain = '0;
            step_length   = '0;
            substeps      = 1;
            current       = '0;
            speed         = '0;
            angle         = '0;
            failures      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                REG_VOLT_GAIN:     volt_gain     = data;
                REG_CURRENT_DECAY: current_decay = data;
                REG_BACK_EMF_GAIN: back_emf_gain = data;
                REG_TORQUE_GAIN:   torque_gain   = data;
                REG_FRICTION_GAIN: friction_gain = data;
                REG_STEP_LENGTH:   step_length   = data;
                REG_SUBSTEPS:      substeps      = data[SUBSTEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact product, floored to 16 fraction bits
        static function longint scaled(logic signed [COEF_W-1:0] a,
                                       logic signed [COEF_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC_W;
        endfunction

        static function logic signed [COEF_W-1:0] clip(longint v);
            if (v > Q_HIGH)
                return SAT_MAX;
            if (v < Q_LOW)
                return SAT_MIN;
            return v[COEF_W-1:0];
        endfunction

        function void note_request(logic signed [COEF_W-1:0] volts);
            int           n;
            longint       next_current;
            longint       next_speed;
            longint       turn;
            motor_state_t after;
            n = substeps;
            if (n == 0)
                n = 1;
            if (n > STEP_LIMIT)
                n = STEP_LIMIT;
            for (int k = 0; k < n; k++)
            begin
                next_current = longint'(current) + scaled(volt_gain, volts)
                               - scaled(current_decay, current)
                               - scaled(back_emf_gain, speed);
                next_speed   = longint'(speed) + scaled(torque_gain, current)
                               - scaled(friction_gain, speed);
                turn         = scaled(step_length, speed);
                angle        = angle + turn[ANGLE_W-1:0];
                current      = clip(next_current);
                speed        = clip(next_speed);
            end
            after.current = current;
            after.speed   = speed;
            after.angle   = angle;
            expected_states.push_back(after);
        endfunction

        function void check_result(logic signed [COEF_W-1:0] got_current,
                                   logic signed [COEF_W-1:0] got_speed,
                                   logic [ANGLE_W-1:0]       got_angle);
            motor_state_t want;
            if (expected_states.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: current %h speed %h angle %h",
                             got_current, got_speed, got_angle);
                return;
            end
            want = expected_states.pop_front();
            if (want.current !== got_current || want.speed !== got_speed ||
                want.angle !== got_angle)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: current exp %h got %h, speed exp %h got %h, angle exp %h got %h",
                             want.current, got_current, want.speed, got_speed,
                             want.angle, got_angle);
            end
        endfunction

        function int pending();
            return expected_states.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COEF_W-1:0] voltage;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [COEF_W-1:0] current_out;
    logic signed [COEF_W-1:0] speed_out;
    logic signed [ANGLE_W-1:0] angle_out;

    int tx_idle_pct;
    int rx_idle_pct;
    int quiet_cycles;

    motor_step_scoreboard motor;

    dc_motor_euler_step_core #(
        .MAX_SUBSTEPS(STEP_LIMIT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .voltage    (voltage),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .current_out(current_out),
        .speed_out  (speed_out),
        .angle_out  (angle_out)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Coefficient mix: full random, motor-like small values, extremes, zero, unity
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2, 3:    return $urandom_range(32'h0002_0000);
            4:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            5:       return $urandom_range(1) ? Q_MAX : Q_MIN;
            6:       return '0;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_voltage();
        case ($urandom_range(7))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(32'h0030_0000) - 32'h0018_0000;
            6:          return $urandom_range(1) ? Q_MAX : Q_MIN;
            default:    return '0;
        endcase
    endfunction

    // Receiver: check a result on every accepted handshake, then draw the
    // stall for the next cycle. Values read here are those before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                motor.check_result(current_out, speed_out, angle_out);
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: end the run if no channel moves anything for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one voltage request, with random idle cycles ahead of it, and
    // hold it until the core takes it.
    task automatic send_voltage(input logic [COEF_W-1:0] volts);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        voltage  <= volts;
        do
            @(posedge clk);
        while (in_stall);
        motor.note_request(volts);
    endtask

    // Drop valid and hold off until every outstanding result has drained;
    // call only right after a request was taken, so something is pending.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (motor.pending() != 0);
    endtask

    // Write every register in index order, optionally followed by a stray
    // write to the unused index. Call only while the core is idle.
    task automatic program_motor(input logic [COEF_W-1:0] vg, cd, be, tq, fr, sl,
                                 input logic [COEF_W-1:0] nsub, input bit stray);
        logic [COEF_W-1:0]    vals [8];
        logic [CFG_IDX_W-1:0] last;
        vals[REG_VOLT_GAIN]     = vg;
        vals[REG_CURRENT_DECAY] = cd;
        vals[REG_BACK_EMF_GAIN] = be;
        vals[REG_TORQUE_GAIN]   = tq;
        vals[REG_FRICTION_GAIN] = fr;
        vals[REG_STEP_LENGTH]   = sl;
        vals[REG_SUBSTEPS]      = nsub;
        vals[REG_UNUSED]        = $urandom;
        last = stray ? REG_UNUSED : REG_SUBSTEPS;
        for (int idx = REG_VOLT_GAIN; idx <= last; idx++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(idx);
            cfg_data  <= vals[idx];
            do
                @(posedge clk);
            while (!cfg_ready);
            motor.set_reg(CFG_IDX_W'(idx), vals[idx]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int boundary;
        int phase_items;
        int directed_count;
        logic [COEF_W-1:0] nsub;

        // Drive every input to a known value before the first edge
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_VOLT_GAIN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        voltage      = '0;
        out_stall    = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        quiet_cycles = 0;
        motor        = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: all gains zero, so the state must stay at zero
        send_voltage(Q_MAX);
        send_voltage(Q_MIN);
        wait_drained();

        // Unity gains with a substep count of zero (taken as one): drive the
        // current and speed into saturation both ways
        program_motor(Q_ONE, '0, '0, Q_ONE, '0, Q_ONE, '0, 1'b0);
        repeat (3) send_voltage(Q_MAX);
        repeat (3) send_voltage(Q_MIN);
        send_voltage('0);
        send_voltage('1);
        send_voltage(32'h0000_0001);
        wait_drained();

        // Extreme coefficients and an all-ones substep write, clamped to the
        // maximum: the large angle steps make the angle wrap
        program_motor(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '1, 1'b0);
        send_voltage(Q_MIN);
        send_voltage(Q_MAX);
        send_voltage(32'h0000_0001);
        send_voltage('1);
        send_voltage('0);
        wait_drained();

        // Just past the substep limit, negative step length, stray write
        program_motor(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                      Q_MIN, 32'd17, 1'b1);
        send_voltage(Q_ONE);
        send_voltage(-Q_ONE);
        send_voltage(pick_voltage());
        wait_drained();

        directed_count = 19;
        sent = directed_count;

        // Random phases under three idling patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 81;
                end
                1:
                begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 15;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            boundary = directed_count + (mode + 1) * (ITEM_TARGET - directed_count) / 3;
            while (sent < boundary)
            begin
                // Mostly a few substeps; now and then zero, the maximum or beyond
                case ($urandom_range(15))
                    0:       nsub = 0;
                    1:       nsub = $urandom_range(31, STEP_LIMIT + 1);
                    2:       nsub = STEP_LIMIT;
                    3, 4:    nsub = $urandom_range(STEP_LIMIT - 1, 5);
                    default: nsub = $urandom_range(4, 1);
                endcase
                if ($urandom_range(1))
                    nsub = nsub | ($urandom & ~32'h1F);

                if ($urandom_range(1))
                    // Well-behaved motor: positive losses keep the state bounded
                    program_motor($urandom_range(32'h4000, 32'h100),
                                  $urandom_range(32'h4000, 32'h100),
                                  $urandom_range(32'h4000),
                                  $urandom_range(32'h8000),
                                  $urandom_range(32'h2000),
                                  $urandom_range(32'h1000, 32'h10),
                                  nsub, $urandom_range(3) == 0);
                else
                    program_motor(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                                  pick_coef(), pick_coef(), nsub, $urandom_range(3) == 0);

                phase_items = $urandom_range(90, 30);
                for (int i = 0; i < phase_items; i++)
                begin
                    // Occasionally hold off until the pipeline is empty
                    if (i != 0 && $urandom_range(199) == 0)
                        wait_drained();
                    send_voltage(pick_voltage());
                    sent++;
                end
                wait_drained();
            end
        end

        // Allow time for any stray result to show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (motor.failures == 0 && motor.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
